### rtl/mecanum_wheel_speed_ramp_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mecanum wheel speed ramp
// Concurrent checks on i_clk, disabled while i_rst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef MECANUM_WHEEL_SPEED_RAMP_ASSERT_SVH
`define MECANUM_WHEEL_SPEED_RAMP_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define MWSR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define MWSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MWSR_ASSERT_NOW(lbl, ante, cons, msg)
`define MWSR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/mwsr_pkg.sv
// ----------------------------------------------------------------------------
// mwsr_pkg
// Shared types, micro-op codes and helpers for the mecanum wheel speed ramp.
// ----------------------------------------------------------------------------
package mwsr_pkg;

    localparam int NUM_WHEELS = 4;
    localparam int WHEEL_W    = 2;
    localparam int SPEED_W    = 32;
    localparam int TIME_W     = 48;
    localparam int PC_W       = 4;

    // 0.01 in Q16.16, rounded up
    localparam logic signed [32:0] SMALL_ERR = 33'sd656;
    // ramp step never needs to exceed 2^33
    localparam logic [33:0]        STEP_CAP  = 34'h2_0000_0000;

    localparam logic [31:0] GAIN_RESET   = 32'd218453;
    localparam logic [31:0] PERIOD_RESET = 32'd655;

    // register map, word index
    typedef enum logic [2:0] {
        REG_GAIN_0   = 3'd0,
        REG_GAIN_1   = 3'd1,
        REG_GAIN_2   = 3'd2,
        REG_GAIN_3   = 3'd3,
        REG_GEOM_0   = 3'd4,
        REG_GEOM_1   = 3'd5,
        REG_ACCEL    = 3'd6,
        REG_PERIOD   = 3'd7
    } t_reg;

    // datapath operation of one microcode step
    typedef enum logic [3:0] {
        OP_NOP     = 4'd0,
        OP_CHECK   = 4'd1,
        OP_SAVE_P1 = 4'd2,
        OP_STEP    = 4'd3,
        OP_SAVE_T0 = 4'd4,
        OP_SAVE_T1 = 4'd5,
        OP_SUM     = 4'd6,
        OP_DESIRED = 4'd7,
        OP_ERR     = 4'd8,
        OP_CLAMP   = 4'd9,
        OP_RAMP    = 4'd10,
        OP_FINISH  = 4'd11
    } t_op;

    // multiplier operand pair
    typedef enum logic [2:0] {
        MS_NONE     = 3'd0,
        MS_ACC_DTHI = 3'd1,
        MS_ACC_DTLO = 3'd2,
        MS_WZ_G0    = 3'd3,
        MS_WZ_G1    = 3'd4,
        MS_GAIN     = 3'd5
    } t_msel;

    // sequencing of the step counter
    typedef enum logic [1:0] {
        J_NEXT = 2'd0,
        J_FAIL = 2'd1,
        J_LOOP = 2'd2,
        J_END  = 2'd3
    } t_jmp;

    typedef struct packed {
        t_op              op;
        t_msel            msel;
        t_jmp             jmp;
        logic [PC_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        logic fail;
        logic last_wheel;
    } t_dp_status;

    typedef struct packed {
        logic [NUM_WHEELS-1:0][31:0] gain;
        logic signed [31:0]          geom_0;
        logic signed [31:0]          geom_1;
        logic [30:0]                 accel;
        logic [31:0]                 period;
    } t_cfg;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
        if (x > 50'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (x < -50'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return x[31:0];
        end
    endfunction

    // wheels 1 and 2 subtract vy
    function automatic logic vy_neg(input logic [WHEEL_W-1:0] w);
        return (w == WHEEL_W'(1)) || (w == WHEEL_W'(2));
    endfunction

    // wheels 1 and 3 subtract the yaw term
    function automatic logic wz_neg(input logic [WHEEL_W-1:0] w);
        return w[0];
    endfunction

endpackage

### rtl/mwsr_mul.sv
// ----------------------------------------------------------------------------
// mwsr_mul
// Shared 33x33 signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module mwsr_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_p
);
    logic signed [65:0] r_p;

    // one product per cycle
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

### rtl/mwsr_seq.sv
// ----------------------------------------------------------------------------
// mwsr_seq
// Microcode sequencer: control ROM, step counter and conditional jumps.
// ----------------------------------------------------------------------------
module mwsr_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  mwsr_pkg::t_dp_status i_status,
    input  logic                i_out_busy,
    output mwsr_pkg::t_uword    o_ctrl,
    output logic                o_busy
);
    import mwsr_pkg::*;

    logic            r_run;
    logic [PC_W-1:0] r_pc;
    t_uword          w_word;

    // control program for one tick
    function automatic t_uword rom(input logic [PC_W-1:0] pc);
        t_uword u;
        u = '{op: OP_NOP, msel: MS_NONE, jmp: J_END, target: '0};
        case (pc)
            4'd0:  u = '{op: OP_CHECK,   msel: MS_ACC_DTHI, jmp: J_FAIL, target: '0};
            4'd1:  u = '{op: OP_SAVE_P1, msel: MS_ACC_DTLO, jmp: J_NEXT, target: '0};
            4'd2:  u = '{op: OP_STEP,    msel: MS_WZ_G0,    jmp: J_NEXT, target: '0};
            4'd3:  u = '{op: OP_SAVE_T0, msel: MS_WZ_G1,    jmp: J_NEXT, target: '0};
            4'd4:  u = '{op: OP_SAVE_T1, msel: MS_NONE,     jmp: J_NEXT, target: '0};
            // per-wheel loop body
            4'd5:  u = '{op: OP_SUM,     msel: MS_NONE,     jmp: J_NEXT, target: '0};
            4'd6:  u = '{op: OP_NOP,     msel: MS_GAIN,     jmp: J_NEXT, target: '0};
            4'd7:  u = '{op: OP_DESIRED, msel: MS_NONE,     jmp: J_NEXT, target: '0};
            4'd8:  u = '{op: OP_ERR,     msel: MS_NONE,     jmp: J_NEXT, target: '0};
            4'd9:  u = '{op: OP_CLAMP,   msel: MS_NONE,     jmp: J_NEXT, target: '0};
            4'd10: u = '{op: OP_RAMP,    msel: MS_NONE,     jmp: J_LOOP, target: 4'd5};
            4'd11: u = '{op: OP_FINISH,  msel: MS_NONE,     jmp: J_END,  target: '0};
            default: u = '{op: OP_NOP,   msel: MS_NONE,     jmp: J_END,  target: '0};
        endcase
        return u;
    endfunction

    assign w_word = rom(r_pc);

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_pc  <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_pc  <= '0;
        end else if (r_run) begin
            case (w_word.jmp)
                J_NEXT: r_pc <= r_pc + 1'b1;
                J_FAIL: begin
                    if (i_status.fail) begin
                        r_run <= 1'b0;
                    end else begin
                        r_pc <= r_pc + 1'b1;
                    end
                end
                J_LOOP: begin
                    if (i_status.last_wheel) begin
                        r_pc <= r_pc + 1'b1;
                    end else begin
                        r_pc <= w_word.target;
                    end
                end
                J_END: begin
                    if (!i_out_busy) begin
                        r_run <= 1'b0;
                    end
                end
                default: r_run <= 1'b0;
            endcase
        end
    end

    // control word; the last step waits while the output is still held
    always_comb begin
        o_ctrl = w_word;
        if (!r_run) begin
            o_ctrl = '{op: OP_NOP, msel: MS_NONE, jmp: J_NEXT, target: '0};
        end else if (w_word.jmp == J_END && i_out_busy) begin
            o_ctrl.op = OP_NOP;
        end
    end

    assign o_busy = r_run;

endmodule

### rtl/mwsr_dp.sv
// ----------------------------------------------------------------------------
// mwsr_dp
// Datapath: targets, timing, per-wheel kinematics and ramp under microcode.
// ----------------------------------------------------------------------------
module mwsr_dp (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  mwsr_pkg::t_uword                                i_ctrl,
    input  mwsr_pkg::t_cfg                                  i_cfg,
    input  logic                                            i_cmd_we,
    input  logic                                            i_start,
    input  logic signed [31:0]                              i_vx,
    input  logic signed [31:0]                              i_vy,
    input  logic signed [31:0]                              i_wz,
    input  logic [mwsr_pkg::TIME_W-1:0]                     i_now,
    input  logic [mwsr_pkg::NUM_WHEELS-1:0][mwsr_pkg::SPEED_W-1:0] i_meas,
    output mwsr_pkg::t_dp_status                            o_status,
    output logic                                            o_fin,
    output logic [mwsr_pkg::NUM_WHEELS-1:0][mwsr_pkg::SPEED_W-1:0] o_res
);
    import mwsr_pkg::*;

    // architectural state
    logic signed [31:0]        r_vx, r_vy, r_wz;
    logic [TIME_W-1:0]         r_last;
    logic signed [SPEED_W-1:0] r_inst [NUM_WHEELS];
    logic [WHEEL_W-1:0]        r_wheel;

    // working registers
    logic [TIME_W-1:0]                      r_now;
    logic [TIME_W:0]                        r_dt;
    logic [NUM_WHEELS-1:0][SPEED_W-1:0]     r_meas;
    logic [62:0]                            r_p1;
    logic [33:0]                            r_step;
    logic signed [47:0]                     r_t0, r_t1;
    logic signed [31:0]                     r_sum, r_des;
    logic signed [32:0]                     r_err;
    logic                                   r_zero, r_pass;
    logic signed [34:0]                     r_d;
    logic [NUM_WHEELS-1:0][SPEED_W-1:0]     r_res;

    logic signed [32:0] w_mul_a, w_mul_b;
    logic signed [65:0] w_prod;
    logic [34:0]        w_step_sum;
    logic signed [47:0] w_t;
    logic signed [49:0] w_vx_e, w_vy_e, w_t_e, w_sum_e;
    logic signed [31:0] w_meas, w_meas_adj, w_base, w_ramp;
    logic signed [34:0] w_err35, w_step35, w_d;
    logic signed [49:0] w_ramp_e;
    logic               w_small;

    // multiplier operand selection
    always_comb begin
        case (i_ctrl.msel)
            MS_ACC_DTHI: begin
                w_mul_a = {2'b00, i_cfg.accel};
                w_mul_b = {1'b0, r_dt[47:16]};
            end
            MS_ACC_DTLO: begin
                w_mul_a = {2'b00, i_cfg.accel};
                w_mul_b = {17'b0, r_dt[15:0]};
            end
            MS_WZ_G0: begin
                w_mul_a = {r_wz[31], r_wz};
                w_mul_b = {i_cfg.geom_0[31], i_cfg.geom_0};
            end
            MS_WZ_G1: begin
                w_mul_a = {r_wz[31], r_wz};
                w_mul_b = {i_cfg.geom_1[31], i_cfg.geom_1};
            end
            MS_GAIN: begin
                w_mul_a = {1'b0, i_cfg.gain[r_wheel]};
                w_mul_b = {r_sum[31], r_sum};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    mwsr_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // ramp step = accel*dt/2^16 from the high and low products
    assign w_step_sum = {1'b0, r_p1[33:0]} + {4'b0, w_prod[46:16]};

    // wheel sum vx +/- vy +/- yaw term
    assign w_t     = r_wheel[0] ? r_t1 : r_t0;
    assign w_vx_e  = {{18{r_vx[31]}}, r_vx};
    assign w_vy_e  = {{18{r_vy[31]}}, r_vy};
    assign w_t_e   = {{2{w_t[47]}}, w_t};
    assign w_sum_e = w_vx_e + (vy_neg(r_wheel) ? -w_vy_e : w_vy_e)
                   + (wz_neg(r_wheel) ? -w_t_e : w_t_e);

    // error against measurement; a zero target drops the measurement
    assign w_meas     = r_meas[r_wheel];
    assign w_meas_adj = (r_des == 32'sd0) ? 32'sd0 : w_meas;

    // clamp the error to +/- step
    assign w_err35  = {{2{r_err[32]}}, r_err};
    assign w_step35 = {1'b0, r_step};
    assign w_small  = (r_err < SMALL_ERR) && (r_err > -SMALL_ERR);
    always_comb begin
        if (!r_err[32]) begin
            w_d = (w_err35 < w_step35) ? w_err35 : w_step35;
        end else begin
            w_d = (w_err35 > -w_step35) ? w_err35 : -w_step35;
        end
    end

    // instructed speed update
    assign w_base   = r_zero ? 32'sd0 : r_inst[r_wheel];
    assign w_ramp_e = {{18{w_base[31]}}, w_base} + {{15{r_d[34]}}, r_d};
    assign w_ramp   = sat32(w_ramp_e);

    // state with a defined reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx    <= '0;
            r_vy    <= '0;
            r_wz    <= '0;
            r_last  <= '0;
            r_wheel <= '0;
            for (int i = 0; i < NUM_WHEELS; i++) begin
                r_inst[i] <= '0;
            end
        end else begin
            if (i_cmd_we) begin
                r_vx <= i_vx;
                r_vy <= i_vy;
                r_wz <= i_wz;
            end
            case (i_ctrl.op)
                OP_CHECK:  r_wheel <= '0;
                OP_RAMP: begin
                    r_inst[r_wheel] <= r_pass ? w_base : w_ramp;
                    r_wheel         <= r_wheel + 1'b1;
                end
                OP_FINISH: r_last <= r_now;
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_now  <= i_now;
            r_dt   <= {1'b0, i_now} - {1'b0, r_last};
            r_meas <= i_meas;
        end
        case (i_ctrl.op)
            OP_SAVE_P1: r_p1 <= w_prod[62:0];
            OP_STEP: begin
                if ((|r_p1[62:33]) || (w_step_sum > {1'b0, STEP_CAP})) begin
                    r_step <= STEP_CAP;
                end else begin
                    r_step <= w_step_sum[33:0];
                end
            end
            OP_SAVE_T0: r_t0 <= w_prod[63:16];
            OP_SAVE_T1: r_t1 <= w_prod[63:16];
            OP_SUM:     r_sum <= sat32(w_sum_e);
            OP_DESIRED: r_des <= sat32(w_prod[65:16]);
            OP_ERR: begin
                r_err  <= {r_des[31], r_des} - {w_meas_adj[31], w_meas_adj};
                r_zero <= (r_des == 32'sd0);
            end
            OP_CLAMP: begin
                r_pass <= (i_cfg.accel == '0) || w_small;
                r_d    <= w_d;
            end
            OP_RAMP:    r_res[r_wheel] <= r_pass ? r_des : w_ramp;
            default: ;
        endcase
    end

    // status back to the sequencer
    assign o_status.fail       = r_dt[TIME_W] || (r_dt[TIME_W-1:0] < {16'b0, i_cfg.period});
    assign o_status.last_wheel = (r_wheel == WHEEL_W'(NUM_WHEELS - 1));
    assign o_fin               = (i_ctrl.op == OP_FINISH);
    assign o_res               = r_res;

endmodule

### rtl/mecanum_wheel_speed_ramp.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_ramp
// Four-wheel mecanum speed controller with acceleration ramp, Q16.16.
// ----------------------------------------------------------------------------
// A command transfer (tuser = 0) stores vx, vy and wz and does not occupy the
// block. A tick transfer (tuser = 1) runs the microcode program on the shared
// 33x33 multiplier: a period check step (a tick inside the update period ends
// there with no result), four setup steps, six steps per wheel and one finish
// step. The result is held in an output register; the next transfer is
// accepted as soon as the program ends, and the finish step waits only while
// an earlier result is still held there.
`include "mecanum_wheel_speed_ramp_assert.svh"

module mecanum_wheel_speed_ramp (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // stream in
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata, low bit up: cmd_vx[31:0], cmd_vy[63:32], cmd_wz[95:64],
    // now_time[143:96], meas_speed_0[175:144], meas_speed_1[207:176],
    // meas_speed_2[239:208], meas_speed_3[271:240]
    input  logic [271:0] s_axis_tdata,
    // tuser: func[0]
    input  logic         s_axis_tuser,
    // stream out
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata, low bit up: drive_speed_0[31:0], drive_speed_1[63:32],
    // drive_speed_2[95:64], drive_speed_3[127:96]
    output logic [127:0] m_axis_tdata,
    // register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import mwsr_pkg::*;

    t_cfg       r_cfg;
    logic       r_out_valid;
    logic [NUM_WHEELS-1:0][SPEED_W-1:0] r_out_data;

    logic       w_in_xfer, w_tick, w_cmd;
    logic       w_cfg_wr, w_busy, w_out_busy, w_fin;
    t_reg       w_reg;
    t_uword     w_ctrl;
    t_dp_status w_status;
    logic [NUM_WHEELS-1:0][SPEED_W-1:0] w_res;
    logic [NUM_WHEELS-1:0][SPEED_W-1:0] w_meas;

    // input transfer
    assign s_axis_tready = !w_busy;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_tick        = w_in_xfer && s_axis_tuser;
    assign w_cmd         = w_in_xfer && !s_axis_tuser;

    assign w_meas[0] = s_axis_tdata[175:144];
    assign w_meas[1] = s_axis_tdata[207:176];
    assign w_meas[2] = s_axis_tdata[239:208];
    assign w_meas[3] = s_axis_tdata[271:240];

    // configuration registers
    assign pready   = 1'b1;
    assign w_reg    = t_reg'(paddr[4:2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain   <= {NUM_WHEELS{GAIN_RESET}};
            r_cfg.geom_0 <= '0;
            r_cfg.geom_1 <= '0;
            r_cfg.accel  <= '0;
            r_cfg.period <= PERIOD_RESET;
        end else if (w_cfg_wr) begin
            case (w_reg)
                REG_GAIN_0: r_cfg.gain[0] <= pwdata;
                REG_GAIN_1: r_cfg.gain[1] <= pwdata;
                REG_GAIN_2: r_cfg.gain[2] <= pwdata;
                REG_GAIN_3: r_cfg.gain[3] <= pwdata;
                REG_GEOM_0: r_cfg.geom_0  <= pwdata;
                REG_GEOM_1: r_cfg.geom_1  <= pwdata;
                REG_ACCEL:  r_cfg.accel   <= pwdata[30:0];
                REG_PERIOD: r_cfg.period  <= pwdata;
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (w_reg)
            REG_GAIN_0: prdata = r_cfg.gain[0];
            REG_GAIN_1: prdata = r_cfg.gain[1];
            REG_GAIN_2: prdata = r_cfg.gain[2];
            REG_GAIN_3: prdata = r_cfg.gain[3];
            REG_GEOM_0: prdata = r_cfg.geom_0;
            REG_GEOM_1: prdata = r_cfg.geom_1;
            REG_ACCEL:  prdata = {1'b0, r_cfg.accel};
            REG_PERIOD: prdata = r_cfg.period;
            default:    prdata = '0;
        endcase
    end

    // sequencer and datapath
    assign w_out_busy = r_out_valid && !m_axis_tready;

    mwsr_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_tick),
        .i_status   (w_status),
        .i_out_busy (w_out_busy),
        .o_ctrl     (w_ctrl),
        .o_busy     (w_busy)
    );

    mwsr_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_cfg    (r_cfg),
        .i_cmd_we (w_cmd),
        .i_start  (w_tick),
        .i_vx     (s_axis_tdata[31:0]),
        .i_vy     (s_axis_tdata[63:32]),
        .i_wz     (s_axis_tdata[95:64]),
        .i_now    (s_axis_tdata[143:96]),
        .i_meas   (w_meas),
        .o_status (w_status),
        .o_fin    (w_fin),
        .o_res    (w_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_out_data <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // checks
    `MWSR_ASSERT_NEXT(a_tick_occupies, w_tick, !s_axis_tready, "tick did not start the program")
    `MWSR_ASSERT_NEXT(a_cmd_no_busy, w_cmd, s_axis_tready, "command occupied the block")
    `MWSR_ASSERT_NOW(a_fin_free, w_fin, !w_out_busy, "result loaded over a held result")
    `MWSR_ASSERT_NEXT(a_fin_loads, w_fin, r_out_valid && (m_axis_tdata == $past(w_res)), "result not presented")

endmodule

### test/mecanum_wheel_speed_ramp_tb.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_ramp_tb
// Self-checking bench for the mecanum wheel speed ramp. Commands and control
// ticks go in over the input stream, configuration over the APB port. A
// scoreboard class recomputes the four wheel speed instructions of every
// updating tick and compares them with each output transfer. Both stream
// sides idle at random, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module mecanum_wheel_speed_ramp_tb;
    import mwsr_pkg::*;

    localparam logic        FUNC_COMMAND  = 1'b0;
    localparam logic        FUNC_TICK     = 1'b1;
    localparam longint      S32_MAX       = 64'sd2147483647;
    localparam longint      S32_MIN       = -64'sd2147483648;
    localparam longint      SLEW_DEADBAND = 64'sd656;
    localparam logic [63:0] RAMP_STEP_CAP = 64'h2_0000_0000;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          QUIET_LIMIT   = 3000;
    localparam int          PHASES        = 5;
    localparam int          PHASE_ITEMS   = 130;

    typedef logic [NUM_WHEELS-1:0][31:0] t_wheel_word;

    // one input transfer, fields in tdata order from the top down
    typedef struct packed {
        t_wheel_word meas;
        logic [47:0] now;
        logic [31:0] wz;
        logic [31:0] vy;
        logic [31:0] vx;
        logic        func;
    } t_ramp_item;

    // ------------------------------------------------------------------------
    // scoreboard: mirror of the controller state and queue of due speeds
    // ------------------------------------------------------------------------
    class t_speed_scoreboard;
        logic [31:0]        gain [NUM_WHEELS];
        logic signed [31:0] geom [2];
        logic [30:0]        accel;
        logic [31:0]        period;
        logic signed [31:0] target_vx;
        logic signed [31:0] target_vy;
        logic signed [31:0] target_wz;
        logic [47:0]        last_tick;
        logic signed [31:0] ramp_speed [NUM_WHEELS];
        t_wheel_word        last_drive;
        t_wheel_word        pending_drive [$];
        int n_mismatch, n_checked, n_cmds, n_updates, n_skipped, n_ramped, n_direct;

        function new();
            for (int w = 0; w < NUM_WHEELS; w++) begin
                gain[w]       = GAIN_RESET;
                ramp_speed[w] = '0;
            end
            geom[0]    = '0;
            geom[1]    = '0;
            accel      = '0;
            period     = PERIOD_RESET;
            target_vx  = '0;
            target_vy  = '0;
            target_wz  = '0;
            last_tick  = '0;
            last_drive = '0;
            n_mismatch = 0;
            n_checked  = 0;
            n_cmds     = 0;
            n_updates  = 0;
            n_skipped  = 0;
            n_ramped   = 0;
            n_direct   = 0;
        endfunction

        function void set_reg(t_reg r, logic [31:0] v);
            case (r)
                REG_GAIN_0, REG_GAIN_1, REG_GAIN_2, REG_GAIN_3: gain[r] = v;
                REG_GEOM_0: geom[0] = v;
                REG_GEOM_1: geom[1] = v;
                REG_ACCEL:  accel   = v[30:0];
                REG_PERIOD: period  = v;
                default: ;
            endcase
        endfunction

        static function longint clip32(longint x);
            if (x > S32_MAX) return S32_MAX;
            if (x < S32_MIN) return S32_MIN;
            return x;
        endfunction

        // note an accepted input transfer; an updating tick queues its speeds
        function void take_item(t_ramp_item it);
            logic [63:0] dt, acc, step_u;
            longint      stp, yaw, sum, desired, meas, err, d;
            t_wheel_word res;
            if (it.func == FUNC_COMMAND) begin
                target_vx = it.vx;
                target_vy = it.vy;
                target_wz = it.wz;
                n_cmds++;
                return;
            end
            // time running backwards or too soon: nothing happens
            if (it.now < last_tick) begin
                n_skipped++;
                return;
            end
            dt = 64'(it.now) - 64'(last_tick);
            if (dt < 64'(period)) begin
                n_skipped++;
                return;
            end
            acc    = 64'(accel);
            step_u = acc * (dt >> 16) + ((acc * (dt & 64'hFFFF)) >> 16);
            stp    = (step_u > RAMP_STEP_CAP) ? longint'(RAMP_STEP_CAP) : longint'(step_u);
            for (int w = 0; w < NUM_WHEELS; w++) begin
                // inverse kinematics: wheels 1,2 take -vy, wheels 1,3 take -yaw
                yaw = (longint'(target_wz) * longint'(geom[w % 2])) >>> 16;
                sum = longint'(target_vx);
                sum = (w == 1 || w == 2) ? sum - longint'(target_vy)
                                         : sum + longint'(target_vy);
                sum = (w % 2 == 1) ? sum - yaw : sum + yaw;
                sum = clip32(sum);
                desired = clip32((longint'({32'b0, gain[w]}) * sum) >>> 16);
                meas = longint'($signed(it.meas[w]));
                if (desired == 0) begin
                    ramp_speed[w] = '0;
                    meas = 0;
                end
                err = desired - meas;
                // no limit set, or already close enough: pass desired through
                if (accel == '0 || (err < SLEW_DEADBAND && err > -SLEW_DEADBAND)) begin
                    res[w] = desired[31:0];
                    n_direct++;
                end else begin
                    if (err >= 0) d = (err < stp) ? err : stp;
                    else d = (err > -stp) ? err : -stp;
                    ramp_speed[w] = 32'(clip32(longint'(ramp_speed[w]) + d));
                    res[w] = ramp_speed[w];
                    n_ramped++;
                end
            end
            last_tick  = it.now;
            last_drive = res;
            pending_drive.insert(pending_drive.size(), res);
            n_updates++;
        endfunction

        // compare one output transfer with the oldest due speeds
        function void check_drive(t_wheel_word got);
            t_wheel_word want;
            if (pending_drive.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("[%0t] drive result %h with none due", $time, got);
                return;
            end
            want = pending_drive.pop_front();
            n_checked++;
            for (int w = 0; w < NUM_WHEELS; w++) begin
                if (got[w] !== want[w]) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("[%0t] wheel %0d drive speed: expected %0d, got %0d",
                                 $time, w, $signed(want[w]), $signed(got[w]));
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and stimulus signals
    // ------------------------------------------------------------------------
    logic         i_clk;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // tdata, low bit up: cmd_vx, cmd_vy, cmd_wz, now_time, meas_speed_0..3
    logic [271:0] s_axis_tdata  = '0;
    // tuser: func
    logic         s_axis_tuser  = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // tdata, low bit up: drive_speed_0..3
    logic [127:0] m_axis_tdata;
    logic         psel          = 1'b0;
    logic         penable       = 1'b0;
    logic         pwrite        = 1'b0;
    logic [4:0]   paddr         = '0;
    logic [31:0]  pwdata        = '0;
    logic [31:0]  prdata;
    logic         pready;

    t_speed_scoreboard scb = new();
    logic [31:0] cfg_word [8];
    bit          feed_burst = 1'b0;
    bit          sink_burst = 1'b0;
    bit          hold_req   = 1'b0;
    int          n_configs  = 0;

    mecanum_wheel_speed_ramp u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // output side: random stalls, one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : drive_sink
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall = sink_burst ? 0 : $urandom_range(0, 16);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            scb.check_drive(m_axis_tdata);
            if ($urandom_range(0, 29) == 0) sink_burst = !sink_burst;
        end
    end

    // watchdog: stop when no transfer of any kind happens for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable && pwrite && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    // offer one item after a random gap; valid stays up for back-to-back items
    task automatic send_item(input t_ramp_item it);
        int gap;
        gap = feed_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.func;
        s_axis_tdata  <= {it.meas, it.now, it.wz, it.vy, it.vx};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        scb.take_item(it);
    endtask

    // setup and access cycle; psel is left high for a following write
    task automatic write_reg(input t_reg r, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        scb.set_reg(r, v);
    endtask

    task automatic release_bus();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_config();
        for (int i = 0; i < 8; i++) write_reg(t_reg'(i), cfg_word[i]);
        release_bus();
        n_configs++;
    endtask

    // drop valid, wait for all due results, then for any tick still in flight
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (scb.pending_drive.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------------
    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [31:0] pick_velocity();
        case ($urandom_range(0, 9))
            0: return pick_extreme();
            1: return $urandom;
            default: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
        endcase
    endfunction

    // measured speeds mostly follow the last instruction
    function automatic logic [31:0] pick_meas(input int w);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return scb.last_drive[w] + 32'(int'($urandom_range(0, 1600)) - 800);
            4, 5: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
            6: return '0;
            7: return $urandom;
            8: return pick_extreme();
            default: return scb.last_drive[w];
        endcase
    endfunction

    // every field random; the kind-specific builders overwrite what matters
    function automatic t_ramp_item noise_item();
        t_ramp_item it;
        it.func = FUNC_COMMAND;
        it.vx   = $urandom;
        it.vy   = $urandom;
        it.wz   = $urandom;
        it.now  = 48'({$urandom, $urandom});
        for (int w = 0; w < NUM_WHEELS; w++) it.meas[w] = $urandom;
        return it;
    endfunction

    task automatic send_command(input logic [31:0] vx, input logic [31:0] vy,
                                input logic [31:0] wz);
        t_ramp_item it;
        it      = noise_item();
        it.func = FUNC_COMMAND;
        it.vx   = vx;
        it.vy   = vy;
        it.wz   = wz;
        send_item(it);
    endtask

    task automatic send_tick(input logic [47:0] now, input t_wheel_word meas);
        t_ramp_item it;
        it      = noise_item();
        it.func = FUNC_TICK;
        it.now  = now;
        it.meas = meas;
        send_item(it);
    endtask

    function automatic t_wheel_word drive_offset(input int delta);
        t_wheel_word m;
        for (int w = 0; w < NUM_WHEELS; w++) m[w] = scb.last_drive[w] + 32'(delta);
        return m;
    endfunction

    function automatic t_ramp_item random_item();
        t_ramp_item  it;
        logic [63:0] base, dt;
        int          pick;
        it   = noise_item();
        base = 64'(scb.last_tick);
        if ($urandom_range(0, 4) == 0) begin
            it.func = FUNC_COMMAND;
            it.vx   = pick_velocity();
            it.vy   = pick_velocity();
            it.wz   = pick_velocity();
            return it;
        end
        it.func = FUNC_TICK;
        for (int w = 0; w < NUM_WHEELS; w++) it.meas[w] = pick_meas(w);
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
            dt = 64'(scb.period) + $urandom_range(0, 3000);
        end else if (pick < 16) begin
            dt = (scb.period == '0) ? 64'd0 : 64'($urandom_range(0, scb.period - 1));
        end else if (pick < 18 || base < 64'd5002) begin
            dt = 64'(scb.period) + {30'b0, 2'($urandom_range(0, 3)), 32'($urandom)};
        end else begin
            // earlier than the last update
            it.now = 48'(base - 64'd1 - $urandom_range(0, 5000));
            return it;
        end
        it.now = 48'(base + dt);
        return it;
    endfunction

    task automatic random_config();
        for (int w = 0; w < NUM_WHEELS; w++) begin
            case ($urandom_range(0, 5))
                0, 1, 2: cfg_word[w] = $urandom_range(65536, 400000);
                3: cfg_word[w] = $urandom;
                4: cfg_word[w] = 32'hFFFF_FFFF;
                default: cfg_word[w] = $urandom_range(0, 65535);
            endcase
        end
        for (int p = 0; p < 2; p++) begin
            case ($urandom_range(0, 5))
                0, 1, 2, 3: cfg_word[REG_GEOM_0 + p] = int'($urandom_range(0, 1 << 18)) - (1 << 17);
                4: cfg_word[REG_GEOM_0 + p] = $urandom;
                default: cfg_word[REG_GEOM_0 + p] = '0;
            endcase
        end
        case ($urandom_range(0, 5))
            0: cfg_word[REG_ACCEL] = '0;
            1, 2, 3: cfg_word[REG_ACCEL] = $urandom_range(1, 1 << 20);
            4: cfg_word[REG_ACCEL] = $urandom_range(1, 32'h7FFF_FFFF);
            default: cfg_word[REG_ACCEL] = $urandom;
        endcase
        case ($urandom_range(0, 5))
            0: cfg_word[REG_PERIOD] = '0;
            1, 2, 3: cfg_word[REG_PERIOD] = $urandom_range(1, 3000);
            4: cfg_word[REG_PERIOD] = PERIOD_RESET;
            default: cfg_word[REG_PERIOD] = $urandom_range(0, 1 << 20);
        endcase
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_wheel_word zero_meas;
        zero_meas = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: no ramp, zero geometry
        send_tick(48'd655, zero_meas);
        send_command(32'h0001_0000, 32'h0000_8000, 32'h0000_4000);
        send_tick(48'd700, zero_meas);
        send_tick(48'd2000, drive_offset(1000));
        send_tick(48'd1500, zero_meas);
        send_command(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_tick(48'd3000, zero_meas);
        send_command(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_tick(48'd4000, {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
        settle();

        // extreme settings: full gains and geometry, widest accel, no period
        cfg_word[REG_GAIN_0] = 32'hFFFF_FFFF;
        cfg_word[REG_GAIN_1] = 32'hFFFF_FFFF;
        cfg_word[REG_GAIN_2] = 32'hFFFF_FFFF;
        cfg_word[REG_GAIN_3] = 32'hFFFF_FFFF;
        cfg_word[REG_GEOM_0] = 32'h7FFF_FFFF;
        cfg_word[REG_GEOM_1] = 32'h8000_0000;
        cfg_word[REG_ACCEL]  = 32'hFFFF_FFFF;
        cfg_word[REG_PERIOD] = '0;
        load_config();
        send_command(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_tick(48'd4000, {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
        send_command(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0100);
        send_tick(48'd4001, zero_meas);
        settle();

        // ramp settings; wheel 3 has zero gain and so stays at zero
        cfg_word[REG_GAIN_0] = GAIN_RESET;
        cfg_word[REG_GAIN_1] = GAIN_RESET;
        cfg_word[REG_GAIN_2] = GAIN_RESET;
        cfg_word[REG_GAIN_3] = '0;
        cfg_word[REG_GEOM_0] = 32'h0001_0000;
        cfg_word[REG_GEOM_1] = 32'h0000_8000;
        cfg_word[REG_ACCEL]  = 32'h0002_0000;
        cfg_word[REG_PERIOD] = PERIOD_RESET;
        load_config();
        send_command(32'h0001_0000, 32'h0000_8000, 32'h0001_0000);
        send_tick(scb.last_tick + 48'd655, zero_meas);
        send_tick(scb.last_tick + 48'd655, drive_offset(0));
        // long gap: the step covers the whole error
        send_tick(scb.last_tick + 48'h100_0000, drive_offset(0));
        send_tick(scb.last_tick + 48'd655, drive_offset(300));
        // error right below and right at the dead band
        send_tick(scb.last_tick + 48'd655, drive_offset(-655));
        send_tick(scb.last_tick + 48'd655, drive_offset(-656));
        send_command(32'hFFFE_0000, '0, '0);
        send_tick(scb.last_tick + 48'd655,
                  {32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0000});
        send_command('0, '0, '0);
        send_tick(scb.last_tick + 48'd655, drive_offset(5000));
        settle();

        // longest update period
        write_reg(REG_PERIOD, 32'hFFFF_FFFF);
        release_bus();
        send_tick(scb.last_tick + 48'hFFFF_FFFF, drive_offset(0));
        send_tick(scb.last_tick + 48'd100, drive_offset(0));

        // random phases, each under its own settings
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            random_config();
            load_config();
            if (ph == 2) hold_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 29) == 0) feed_burst = !feed_burst;
                send_item(random_item());
            end
        end

        // top of the time range, where only a zero period lets ticks update
        settle();
        write_reg(REG_PERIOD, '0);
        release_bus();
        send_command(pick_velocity(), pick_velocity(), pick_velocity());
        send_tick(48'hFFFF_FFFF_FFFF, drive_offset(0));
        send_tick(48'hFFFF_FFFF_FFFF, drive_offset(0));
        settle();

        $display("covered %0d commands, %0d updating and %0d idle ticks over %0d settings",
                 scb.n_cmds, scb.n_updates, scb.n_skipped, n_configs + 2);
        $display("wheel updates: %0d ramped, %0d passed through; %0d results checked",
                 scb.n_ramped, scb.n_direct, scb.n_checked);
        if (scb.n_mismatch == 0 && scb.pending_drive.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     scb.n_mismatch, scb.pending_drive.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
